// ===== design/cfpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the colour palette for the carpet fractal pixel generator.
// No dependencies; every other file of the block imports this package.
package cfpg_pkg;

  // Field and register widths
  localparam int COORD_BITS     = 12;
  localparam int MAX_LEVELS     = 8;
  localparam int BASE_BITS      = 3;
  localparam int WIDTH_BITS     = 13;
  localparam int FRAME_BITS     = 16;
  localparam int COLOUR_BITS    = 24;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 13;
  localparam int DIGIT_BITS     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE         = 1'b0,
    REG_SCREEN_WIDTH = 1'b1
  } cfg_reg_t;

  // Base range and reset values
  localparam logic [BASE_BITS-1:0]  BASE_THREE   = BASE_BITS'(3);
  localparam logic [BASE_BITS-1:0]  BASE_FOUR    = BASE_BITS'(4);
  localparam logic [BASE_BITS-1:0]  BASE_FIVE    = BASE_BITS'(5);
  localparam logic [BASE_BITS-1:0]  BASE_RESET   = BASE_THREE;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(1024);

  // Reciprocal constants for coordinate division by three and by five
  localparam int DIV3_SHIFT = COORD_BITS + 1;
  localparam int DIV5_SHIFT = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] DIV3_MULT = COORD_BITS'((2**DIV3_SHIFT + 2) / 3);
  localparam logic [COORD_BITS-1:0] DIV5_MULT = COORD_BITS'((2**DIV5_SHIFT + 4) / 5);
  localparam int PROD_BITS = 2 * COORD_BITS + 2;

  // Palette selection: frame / 16 picks the entry (mod 7), frame mod 16 scales it
  localparam int SCALE_BITS      = 4;
  localparam int GROUP_BITS      = FRAME_BITS - SCALE_BITS;
  localparam int PAL_INDEX_BITS  = 3;
  localparam int DIV7_SHIFT      = 15;
  localparam int DIV7_MULT_BITS  = 13;
  localparam logic [DIV7_MULT_BITS-1:0] DIV7_MULT = DIV7_MULT_BITS'((2**DIV7_SHIFT + 6) / 7);
  localparam int DIV7_PROD_BITS  = DIV7_SHIFT + GROUP_BITS;
  localparam int TINT_BITS       = COLOUR_BITS + SCALE_BITS;

  // One item as it moves through the level stages
  typedef struct packed {
    logic [COORD_BITS-1:0] x_rem;
    logic [COORD_BITS-1:0] y_rem;
    logic [WIDTH_BITS-1:0] unit;
    logic                  live;
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } level_t;

  function automatic logic [COLOUR_BITS-1:0] palette_entry(
    input logic [PAL_INDEX_BITS-1:0] idx
  );
    logic [COLOUR_BITS-1:0] entry;
    case (idx)
      3'd0:    entry = 24'h110000;
      3'd1:    entry = 24'h111100;
      3'd2:    entry = 24'h001100;
      3'd3:    entry = 24'h001111;
      3'd4:    entry = 24'h000011;
      3'd5:    entry = 24'h110011;
      3'd6:    entry = 24'h111111;
      default: entry = '0;
    endcase
    return entry;
  endfunction

endpackage

// ===== design/cfpg_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixel requests and colour results.
// Depends on cfpg_pkg for field widths.
interface cfpg_pixel_if;
  import cfpg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [FRAME_BITS-1:0] frame;

  modport source (output valid, output pixel_x, output pixel_y, output frame, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input frame, output ready);
endinterface

interface cfpg_result_if;
  import cfpg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COLOUR_BITS-1:0] colour;
  logic                   in_pattern;

  modport source (output valid, output colour, output in_pattern, input ready);
  modport sink   (input valid, input colour, input in_pattern, output ready);
endinterface

// ===== design/cfpg_level.sv =====
`timescale 1ns / 1ps
// One carpet level: peels base-k digit j off both coordinates and tests it.
// Depends on cfpg_pkg for level_t and the reciprocal constants.
module cfpg_level (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cfpg_pkg::BASE_BITS-1:0]  base,
  input  logic [cfpg_pkg::WIDTH_BITS-1:0] screen_width,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  cfpg_pkg::level_t               up_data,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output cfpg_pkg::level_t               dn_data
);
  import cfpg_pkg::*;

  localparam int SIDE_BITS = WIDTH_BITS + BASE_BITS;
  localparam int QK_BITS   = COORD_BITS + BASE_BITS;

  // Split a coordinate into quotient and remainder by the base
  function automatic logic [COORD_BITS+DIGIT_BITS-1:0] split_digit(
    input logic [COORD_BITS-1:0] v,
    input logic [BASE_BITS-1:0]  k
  );
    logic [COORD_BITS-1:0] recip;
    logic [PROD_BITS-1:0]  prod;
    logic [COORD_BITS-1:0] q;
    logic [QK_BITS-1:0]    qk;
    logic [QK_BITS-1:0]    diff;
    recip = (k == BASE_THREE) ? DIV3_MULT : DIV5_MULT;
    prod  = PROD_BITS'(v) * PROD_BITS'(recip);
    case (k)
      BASE_THREE: begin
        q  = prod[DIV3_SHIFT +: COORD_BITS];
        qk = (QK_BITS'(q) << 1) + QK_BITS'(q);
      end
      BASE_FOUR: begin
        q  = v >> 2;
        qk = QK_BITS'(q) << 2;
      end
      default: begin
        q  = prod[DIV5_SHIFT +: COORD_BITS];
        qk = (QK_BITS'(q) << 2) + QK_BITS'(q);
      end
    endcase
    diff = QK_BITS'(v) - qk;
    return {q, diff[DIGIT_BITS-1:0]};
  endfunction

  logic [SIDE_BITS-1:0]  side;
  logic                  counts;
  logic [COORD_BITS-1:0] qx, qy;
  logic [DIGIT_BITS-1:0] dx, dy;
  logic                  x_inner, y_inner;
  level_t                next;

  // Level side and digit test
  always_comb begin
    side     = SIDE_BITS'(up_data.unit) * SIDE_BITS'(base);
    counts   = up_data.live && (side < SIDE_BITS'(screen_width));
    {qx, dx} = split_digit(up_data.x_rem, base);
    {qy, dy} = split_digit(up_data.y_rem, base);
    x_inner  = (dx != '0) && (dx < (base - BASE_BITS'(1)));
    y_inner  = (dy != '0) && (dy < (base - BASE_BITS'(1)));

    next       = up_data;
    next.x_rem = qx;
    next.y_rem = qy;
    next.unit  = side[WIDTH_BITS-1:0];
    next.live  = counts;
    next.hit   = up_data.hit | (counts & x_inner & y_inner);
  end

  assign up_ready = !dn_valid || dn_ready;

  // Advance the stage register when downstream has room
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= next;
    end
  end

endmodule

// ===== design/cfpg_colour.sv =====
`timescale 1ns / 1ps
// Colour stages: palette index and brightness, then the tinted output register.
// Depends on cfpg_pkg and the result interface in cfpg_if.sv.
module cfpg_colour (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  cfpg_pkg::level_t up_data,
  cfpg_result_if.source    result
);
  import cfpg_pkg::*;

  localparam int Q7X_BITS = GROUP_BITS + 3;

  logic [GROUP_BITS-1:0]     group;
  logic [DIV7_PROD_BITS-1:0] prod7;
  logic [GROUP_BITS-1:0]     q7;
  logic [Q7X_BITS-1:0]       rem7;
  logic                      a_valid;
  logic                      a_ready;
  logic                      a_hit;
  logic [PAL_INDEX_BITS-1:0] a_idx;
  logic [SCALE_BITS-1:0]     a_scale;
  logic [TINT_BITS-1:0]      tint;

  // Palette index: (frame / 16) mod 7 through a reciprocal multiply
  always_comb begin
    group = up_data.frame[FRAME_BITS-1 -: GROUP_BITS];
    prod7 = DIV7_PROD_BITS'(group) * DIV7_PROD_BITS'(DIV7_MULT);
    q7    = prod7[DIV7_SHIFT +: GROUP_BITS];
    rem7  = Q7X_BITS'(group) - ((Q7X_BITS'(q7) << 3) - Q7X_BITS'(q7));
  end

  assign a_ready  = !result.valid || result.ready;
  assign up_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (up_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_hit   <= up_data.hit;
      a_idx   <= rem7[PAL_INDEX_BITS-1:0];
      a_scale <= up_data.frame[SCALE_BITS-1:0];
    end
  end

  // Scale the palette entry by the brightness step
  assign tint = TINT_BITS'(palette_entry(a_idx)) * TINT_BITS'(a_scale);

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (a_ready) begin
      result.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      result.colour     <= a_hit ? tint[COLOUR_BITS-1:0] : '0;
      result.in_pattern <= a_hit;
    end
  end

endmodule

// ===== design/carpet_fractal_pixel_generator.sv =====
`timescale 1ns / 1ps
// Carpet fractal pixel generator: one pixel (x, y, frame) in, one colour out, one
// transaction per clock sustained while the result is accepted: one register stage per
// carpet level, each a reciprocal multiply (a shift for base four) per coordinate that
// takes off one base-k digit, then a palette index stage and a tinted output register.
// Every stage holds under backpressure and collapses bubbles, so a stalled output still
// lets the pipeline fill. Write base and screen_width only while no transaction is in
// flight. Depends on cfpg_pkg, cfpg_if, cfpg_level and cfpg_colour.
module carpet_fractal_pixel_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cfpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cfpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  cfpg_pixel_if.sink                         pixel,
  cfpg_result_if.source                      result
);
  import cfpg_pkg::*;

  logic [BASE_BITS-1:0]  base;
  logic [WIDTH_BITS-1:0] screen_width;
  logic [BASE_BITS-1:0]  eff_base;

  logic   lvl_valid [0:MAX_LEVELS];
  logic   lvl_ready [0:MAX_LEVELS];
  level_t lvl_data  [0:MAX_LEVELS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base         <= BASE_RESET;
      screen_width <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE:         base         <= cfg_data[BASE_BITS-1:0];
        REG_SCREEN_WIDTH: screen_width <= cfg_data[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the base to three through five
  always_comb begin
    if (base < BASE_THREE) begin
      eff_base = BASE_THREE;
    end else if (base > BASE_FIVE) begin
      eff_base = BASE_FIVE;
    end else begin
      eff_base = base;
    end
  end

  // Seed the level pipeline
  always_comb begin
    lvl_valid[0]       = pixel.valid;
    lvl_data[0].x_rem  = pixel.pixel_x;
    lvl_data[0].y_rem  = pixel.pixel_y;
    lvl_data[0].unit   = WIDTH_BITS'(1);
    lvl_data[0].live   = 1'b1;
    lvl_data[0].hit    = 1'b0;
    lvl_data[0].frame  = pixel.frame;
  end

  assign pixel.ready = lvl_ready[0];

  for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_level
    cfpg_level u_level (
      .clk          (clk),
      .rst          (rst),
      .base         (eff_base),
      .screen_width (screen_width),
      .up_valid     (lvl_valid[j]),
      .up_ready     (lvl_ready[j]),
      .up_data      (lvl_data[j]),
      .dn_valid     (lvl_valid[j+1]),
      .dn_ready     (lvl_ready[j+1]),
      .dn_data      (lvl_data[j+1])
    );
  end

  cfpg_colour u_colour (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lvl_valid[MAX_LEVELS]),
    .up_ready (lvl_ready[MAX_LEVELS]),
    .up_data  (lvl_data[MAX_LEVELS]),
    .result   (result)
  );

  // Pixels outside the pattern are black
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.in_pattern |-> result.colour == '0)
    else $error("colour set on a pixel outside the pattern");

  // After the first level a counted item carries a unit equal to the base
  assert property (@(posedge clk) disable iff (rst)
    lvl_valid[1] && lvl_data[1].live |-> lvl_data[1].unit == WIDTH_BITS'(eff_base))
    else $error("first level unit differs from the base");

  // Input stalls only when the first level holds an item
  assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> lvl_valid[1])
    else $error("input stalled with an empty first level");

endmodule
